// ===== rtl/core/open_addressing_hash_table_core_macros.svh =====
// assertion helpers for the hash table core
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_MACROS_SVH
// implication checked at each clock edge outside reset
`define OAHT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication checked outside reset
`define OAHT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== rtl/core/oaht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// shared codes and hash helpers for the hash table core
// ----------------------------------------------------------------------------
package oaht_pkg;
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;
    localparam logic [31:0] HADD = 32'he6546b64;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction
endpackage

// ===== rtl/core/open_addressing_hash_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core
// key/value table with murmur3 hashing and triangular probing
// ----------------------------------------------------------------------------
// One command at a time. After reset a clearing pass zeroes the valid
// memory while s_tready stays low. A command is then accepted in S_IDLE,
// runs the hash steps in S_HASH (some of them a 32x32 multiply), and
// probes the slot memories, each probe a read (S_RD) then a compare
// (S_CMP); a remove hit then moves the last dense-list entry (S_LRD,
// S_MOVE), and S_DONE loads the output register. The unused command
// skips the probes. Add stops at the first free or matching slot; remove
// and get walk all probes of the table on a miss. The next command is
// taken while a result still waits in the output register; the core
// stalls only when a second result is ready and the output register is
// still full.
module open_addressing_hash_table_core #(
    parameter int SLOTS     = 1024,
    parameter int KEY_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] cmd, [33:2] key, [65:34] value_in, zero fill to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [34:3] value_out, [44:35] slot_index,
    // [54:45] entry_index, [65:55] live_count, zero fill to 72
    output logic [71:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW  = $clog2(SLOTS);
    localparam int CW  = AW + 1;
    // log2 of the largest power-of-two table size that fits SLOTS
    localparam int MAXLG = $clog2(SLOTS + 1) - 1;
    localparam logic [31:0] KMASK = (KEY_BYTES >= 4) ? 32'hffffffff
        : ((32'd1 << (8 * KEY_BYTES)) - 32'd1);
    localparam logic [31:0] KLEN = 32'(KEY_BYTES);

    localparam logic [3:0] S_IDLE = 4'd0, S_HASH = 4'd1, S_RD = 4'd2,
        S_CMP = 4'd3, S_LRD = 4'd4, S_CLR = 4'd5, S_MOVE = 4'd6,
        S_DONE = 4'd7;

    // configuration registers
    logic [31:0] seed_reg;
    logic [3:0]  lg_reg;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            lg_reg   <= 4'd10;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == 1'b0) seed_reg <= pwdata;
            else lg_reg <= pwdata[3:0];
        end
    end
    always_comb begin
        prdata = (paddr[2] == 1'b0) ? seed_reg : {28'd0, lg_reg};
    end

    // memories
    logic [31:0] key_mem [SLOTS];
    logic [31:0] val_mem [SLOTS];
    logic [AW-1:0] pos_mem [SLOTS];
    logic [AW-1:0] dense_mem [SLOTS];
    logic        valid_mem [SLOTS];

    logic [3:0]  st_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] key_reg, vin_reg, h_reg;
    logic [3:0]  hstep_reg;
    logic [AW:0] i_reg;
    logic [AW-1:0] off_reg, slot_reg, mask_reg;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] rkey_reg, rval_reg;
    logic [AW-1:0] rpos_reg, rdense_reg;
    logic        out_v_reg;
    logic [65:0] out_data_reg;
    logic [2:0]  o_st_reg;
    logic [31:0] o_val_reg;
    logic [AW-1:0] o_sl_reg, o_en_reg;
    logic        rvalid_reg;

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_data_reg};

    // output register: holds a result until its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg    <= 1'b0;
            out_data_reg <= '0;
        end else if (st_reg == S_DONE && (!out_v_reg || m_tready)) begin
            out_v_reg    <= 1'b1;
            out_data_reg <= {11'(cnt_reg), 10'(o_en_reg), 10'(o_sl_reg), o_val_reg,
                             o_st_reg};
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    // hash step: at most one multiply per step
    logic [31:0] h_next;
    logic [31:0] kb;
    always_comb begin
        kb = key_reg;
        h_next = h_reg;
        unique case (hstep_reg)
            4'd0: h_next = kb * oaht_pkg::C1;
            4'd1: h_next = oaht_pkg::rotl(h_reg, 15) * oaht_pkg::C2;
            4'd2: h_next = (KEY_BYTES >= 4)
                ? oaht_pkg::rotl(seed_reg ^ h_reg, 13) : seed_reg ^ h_reg;
            4'd3: begin
                if (KEY_BYTES >= 4) h_next = h_reg * 32'd5 + oaht_pkg::HADD;
                // second key block is all zero, so it only rotates and scales
                if (KEY_BYTES >= 8)
                    h_next = oaht_pkg::rotl(h_next, 13) * 32'd5 + oaht_pkg::HADD;
            end
            4'd4: h_next = (h_reg ^ KLEN) ^ ((h_reg ^ KLEN) >> 16);
            4'd5: h_next = h_reg * oaht_pkg::F1;
            4'd6: h_next = (h_reg ^ (h_reg >> 13)) * oaht_pkg::F2;
            default: h_next = h_reg ^ (h_reg >> 16);
        endcase
    end

    logic [3:0] lg_eff;
    always_comb begin
        lg_eff = lg_reg;
        if (lg_eff < 4'd1) lg_eff = 4'd1;
        if (32'(lg_eff) > MAXLG) lg_eff = 4'(MAXLG);
    end

    logic [AW-1:0] probe;
    assign probe = (h_reg[AW-1:0] + off_reg) & mask_reg;

    logic [CW-1:0] last_w;
    assign last_w = cnt_reg - CW'(1);

    logic hit;
    assign hit = rvalid_reg && (rkey_reg == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLR;
            clr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            unique case (st_reg)
                S_CLR: begin
                    valid_mem[clr_reg] <= 1'b0;
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(SLOTS - 1)) st_reg <= S_IDLE;
                end
                S_IDLE: if (s_tvalid) begin
                    cmd_reg <= s_tdata[1:0];
                    key_reg <= s_tdata[33:2] & KMASK;
                    vin_reg <= s_tdata[65:34];
                    h_reg <= '0;
                    hstep_reg <= '0;
                    mask_reg <= AW'((32'd1 << lg_eff) - 32'd1);
                    o_st_reg <= oaht_pkg::ST_NOT_FOUND;
                    o_val_reg <= '0; o_sl_reg <= '0; o_en_reg <= '0;
                    st_reg <= S_HASH;
                end
                S_HASH: begin
                    h_reg <= h_next;
                    hstep_reg <= hstep_reg + 4'd1;
                    if (hstep_reg == 4'd7) begin
                        i_reg <= '0; off_reg <= '0;
                        st_reg <= (cmd_reg == oaht_pkg::CMD_UNUSED) ? S_DONE : S_RD;
                    end
                end
                S_RD: begin
                    slot_reg <= probe;
                    rvalid_reg <= valid_mem[probe];
                    rkey_reg <= key_mem[probe];
                    rval_reg <= val_mem[probe];
                    rpos_reg <= pos_mem[probe];
                    st_reg <= S_CMP;
                end
                S_CMP: begin
                    if (cmd_reg == oaht_pkg::CMD_ADD && !rvalid_reg) begin
                        valid_mem[slot_reg] <= 1'b1;
                        key_mem[slot_reg] <= key_reg;
                        val_mem[slot_reg] <= vin_reg;
                        pos_mem[slot_reg] <= cnt_reg[AW-1:0];
                        dense_mem[cnt_reg[AW-1:0]] <= slot_reg;
                        cnt_reg <= cnt_reg + CW'(1);
                        o_st_reg <= oaht_pkg::ST_INSERTED;
                        o_sl_reg <= slot_reg; o_en_reg <= cnt_reg[AW-1:0];
                        st_reg <= S_DONE;
                    end else if (hit) begin
                        o_sl_reg <= slot_reg; o_en_reg <= rpos_reg;
                        if (cmd_reg == oaht_pkg::CMD_ADD) begin
                            val_mem[slot_reg] <= vin_reg;
                            o_st_reg <= oaht_pkg::ST_REPLACED;
                            st_reg <= S_DONE;
                        end else if (cmd_reg == oaht_pkg::CMD_GET) begin
                            o_st_reg <= oaht_pkg::ST_FOUND;
                            o_val_reg <= rval_reg;
                            st_reg <= S_DONE;
                        end else begin
                            o_st_reg <= oaht_pkg::ST_REMOVED;
                            valid_mem[slot_reg] <= 1'b0;
                            st_reg <= S_LRD;
                        end
                    end else if (i_reg == {1'b0, mask_reg}) begin
                        if (cmd_reg == oaht_pkg::CMD_ADD) o_st_reg <= oaht_pkg::ST_FULL;
                        st_reg <= S_DONE;
                    end else begin
                        i_reg <= i_reg + (AW + 1)'(1);
                        off_reg <= off_reg + i_reg[AW-1:0] + AW'(1);
                        st_reg <= S_RD;
                    end
                end
                S_LRD: begin
                    rdense_reg <= dense_mem[last_w[AW-1:0]];
                    st_reg <= S_MOVE;
                end
                S_MOVE: begin
                    dense_mem[rpos_reg] <= rdense_reg;
                    pos_mem[rdense_reg] <= rpos_reg;
                    cnt_reg <= last_w;
                    st_reg <= S_DONE;
                end
                S_DONE: if (!out_v_reg || m_tready) begin
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/oaht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_checker
// port-level checks for the hash table core
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_core_macros.svh"
module oaht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    // a result waits until its transfer
    `OAHT_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // status code is in range
    `OAHT_ASSERT_IMP(a_status, aclk, aresetn, m_tvalid, m_tdata[2:0] <= oaht_pkg::ST_FULL)
    // one command at a time: accepted command stalls input next cycle
    `OAHT_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a not found result touches no slot
    `OAHT_ASSERT_IMP(a_nf, aclk, aresetn, m_tvalid && m_tdata[2:0] == oaht_pkg::ST_NOT_FOUND,
        m_tdata[54:3] == 52'd0)
endmodule

bind open_addressing_hash_table_core oaht_checker u_oaht_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/open_addressing_hash_table_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core_test
// self-checking bench for the murmur3 hash table core
// ----------------------------------------------------------------------------
// A directed table of commands runs first: lookups on the empty table, add,
// replace, get, remove with dense-list compaction and the unused command. A
// full small table follows, then random phases at several seeds and sizes.
// Each command is run through a model of the table kept in the bench, and
// every result transfer is compared field by field against it.
module open_addressing_hash_table_core_test;

    localparam int NSLOT = 1024;
    localparam int CYCLE_LIMIT = 5000000;
    localparam logic [2:0] REG_SEED = 3'd0;
    localparam logic [2:0] REG_SIZE = 3'd4;

    // first member sits in the top bits, so status lands in [2:0]
    typedef struct packed {
        logic [10:0] live_count;
        logic [9:0]  entry_index;
        logic [9:0]  slot_index;
        logic [31:0] value_out;
        logic [2:0]  status;
    } table_result_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] value_in;
        bit          typed;
        logic [2:0]  status;
        logic [10:0] live_count;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    open_addressing_hash_table_core dut (.*);

    // bench copy of the table state
    bit          tbl_valid [NSLOT];
    logic [31:0] tbl_key   [NSLOT];
    logic [31:0] tbl_value [NSLOT];
    logic [9:0]  tbl_pos   [NSLOT];
    logic [9:0]  tbl_dense [NSLOT];
    logic [10:0] tbl_count;
    logic [31:0] cur_seed;
    logic [3:0]  cur_size;

    table_result_t pending_results[$];
    int  fail_count;
    int  cycle_count = 0;
    bit  rx_hold;
    bit  no_idle;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rot_left(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] murmur_hash(logic [31:0] key, logic [31:0] seed);
        logic [31:0] k;
        logic [31:0] h;
        k = key * 32'hcc9e2d51;
        k = rot_left(k, 15);
        k = k * 32'h1b873593;
        h = seed ^ k;
        h = rot_left(h, 13);
        h = h * 32'd5 + 32'he6546b64;
        h = h ^ 32'd4;
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // apply one command to the bench table, return what the core should say
    function automatic table_result_t apply_command(logic [1:0] cmd, logic [31:0] key,
                                                    logic [31:0] val);
        table_result_t r;
        int lg;
        int n;
        logic [31:0] h;
        logic [31:0] s;
        logic [9:0] pos;
        logic [9:0] moved;
        r = '0;
        r.status = oaht_pkg::ST_NOT_FOUND;
        lg = (cur_size < 1) ? 1 : (cur_size > 10) ? 10 : cur_size;
        n = 1 << lg;
        h = murmur_hash(key, cur_seed);
        if (cmd == oaht_pkg::CMD_ADD) begin
            r.status = oaht_pkg::ST_FULL;
            for (int i = 0; i < n; i++) begin
                s = (h + (i * (i + 1)) / 2) & (n - 1);
                if (!tbl_valid[s]) begin
                    pos = tbl_count[9:0];
                    tbl_valid[s] = 1'b1;
                    tbl_key[s] = key;
                    tbl_value[s] = val;
                    tbl_pos[s] = pos;
                    tbl_dense[pos] = s[9:0];
                    tbl_count++;
                    r.status = oaht_pkg::ST_INSERTED;
                    r.slot_index = s[9:0];
                    r.entry_index = pos;
                    break;
                end
                if (tbl_key[s] == key) begin
                    tbl_value[s] = val;
                    r.status = oaht_pkg::ST_REPLACED;
                    r.slot_index = s[9:0];
                    r.entry_index = tbl_pos[s];
                    break;
                end
            end
        end else if (cmd == oaht_pkg::CMD_REMOVE || cmd == oaht_pkg::CMD_GET) begin
            for (int i = 0; i < n; i++) begin
                s = (h + (i * (i + 1)) / 2) & (n - 1);
                if (tbl_valid[s] && tbl_key[s] == key) begin
                    pos = tbl_pos[s];
                    r.slot_index = s[9:0];
                    r.entry_index = pos;
                    if (cmd == oaht_pkg::CMD_GET) begin
                        r.status = oaht_pkg::ST_FOUND;
                        r.value_out = tbl_value[s];
                    end else begin
                        moved = tbl_dense[(tbl_count - 11'd1) & 11'h3ff];
                        tbl_dense[pos] = moved;
                        tbl_pos[moved] = pos;
                        tbl_valid[s] = 1'b0;
                        tbl_count--;
                        r.status = oaht_pkg::ST_REMOVED;
                    end
                    break;
                end
            end
        end
        r.live_count = tbl_count;
        return r;
    endfunction

    // drive one transfer and wait for it; the core is busy on the next edge
    task automatic drive_command(logic [1:0] cmd, logic [31:0] key, logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, val, key, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // one command transfer on the input channel
    task automatic send_command(logic [1:0] cmd, logic [31:0] key, logic [31:0] val,
                                bit idle_ok);
        if (idle_ok && !no_idle) begin
            while ($urandom_range(99) < 28) @(posedge aclk);
        end
        pending_results.push_back(apply_command(cmd, key, val));
        drive_command(cmd, key, val);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_SEED) cur_seed = data;
        else cur_size = data[3:0];
        @(posedge aclk);
    endtask

    // random command mix over a small key pool so hits are common
    task automatic random_phase(int count, int pool);
        logic [1:0] cmd;
        logic [31:0] key;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            cmd = (pick < 45) ? oaht_pkg::CMD_ADD : (pick < 70) ? oaht_pkg::CMD_REMOVE :
                  (pick < 97) ? oaht_pkg::CMD_GET : oaht_pkg::CMD_UNUSED;
            if ($urandom_range(9) == 0) key = $urandom();
            else key = $urandom_range(pool - 1) * 32'h9e3779b1;
            send_command(cmd, key, $urandom(), 1'b1);
        end
    endtask

    // result checking
    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[65:0];
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.value_out !== want.value_out) begin
                    $error("value_out exp %h got %h", want.value_out, got.value_out);
                    fail_count++;
                end
                if (got.slot_index !== want.slot_index) begin
                    $error("slot_index exp %0d got %0d", want.slot_index, got.slot_index);
                    fail_count++;
                end
                if (got.entry_index !== want.entry_index) begin
                    $error("entry_index exp %0d got %0d", want.entry_index,
                           got.entry_index);
                    fail_count++;
                end
                if (got.live_count !== want.live_count) begin
                    $error("live_count exp %0d got %0d", want.live_count, got.live_count);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls, with a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold) m_tready <= 1'b0;
            else m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
        end
    end

    initial begin
        directed_row_t rows[$];
        table_result_t want;
        fail_count = 0;
        rx_hold = 1'b0;
        no_idle = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_seed = 32'd0;
        cur_size = 4'd10;
        tbl_count = '0;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: typed expectations where obvious, else predictor only
        rows = '{
            '{oaht_pkg::CMD_GET,    32'h0,        32'h0,        1,
              oaht_pkg::ST_NOT_FOUND, 11'd0},
            '{oaht_pkg::CMD_REMOVE, 32'hffffffff, 32'h0,        1,
              oaht_pkg::ST_NOT_FOUND, 11'd0},
            '{oaht_pkg::CMD_UNUSED, 32'h12345678, 32'hffffffff, 1,
              oaht_pkg::ST_NOT_FOUND, 11'd0},
            '{oaht_pkg::CMD_ADD,    32'h0,        32'hffffffff, 1,
              oaht_pkg::ST_INSERTED,  11'd1},
            '{oaht_pkg::CMD_ADD,    32'hffffffff, 32'h0,        1,
              oaht_pkg::ST_INSERTED,  11'd2},
            '{oaht_pkg::CMD_ADD,    32'h0,        32'ha5a5a5a5, 1,
              oaht_pkg::ST_REPLACED,  11'd2},
            '{oaht_pkg::CMD_GET,    32'h0,        32'h0,        1,
              oaht_pkg::ST_FOUND,     11'd2},
            '{oaht_pkg::CMD_ADD,    32'h55aa55aa, 32'h12,       0, 3'd0, 11'd0},
            '{oaht_pkg::CMD_REMOVE, 32'h0,        32'h0,        1,
              oaht_pkg::ST_REMOVED,   11'd2},
            '{oaht_pkg::CMD_GET,    32'h55aa55aa, 32'h0,        0, 3'd0, 11'd0},
            '{oaht_pkg::CMD_GET,    32'hffffffff, 32'h0,        0, 3'd0, 11'd0},
            '{oaht_pkg::CMD_UNUSED, 32'hffffffff, 32'h0,        1,
              oaht_pkg::ST_NOT_FOUND, 11'd2},
            '{oaht_pkg::CMD_REMOVE, 32'hffffffff, 32'h0,        0, 3'd0, 11'd0},
            '{oaht_pkg::CMD_REMOVE, 32'h55aa55aa, 32'h0,        1,
              oaht_pkg::ST_REMOVED,   11'd0}
        };
        foreach (rows[i]) begin
            want = apply_command(rows[i].cmd, rows[i].key, rows[i].value_in);
            if (rows[i].typed && want.status !== rows[i].status) begin
                $error("directed row %0d status exp %0d got %0d", i, rows[i].status,
                       want.status);
                fail_count++;
            end
            if (rows[i].typed && want.live_count !== rows[i].live_count) begin
                $error("directed row %0d live_count exp %0d got %0d", i,
                       rows[i].live_count, want.live_count);
                fail_count++;
            end
            pending_results.push_back(want);
            drive_command(rows[i].cmd, rows[i].key, rows[i].value_in);
        end
        wait_drained();

        // smallest table: two adds fill it, the third is full
        write_reg(REG_SIZE, 32'd1);
        write_reg(REG_SEED, 32'hffffffff);
        send_command(oaht_pkg::CMD_ADD, 32'h11, 32'h1, 1'b0);
        send_command(oaht_pkg::CMD_ADD, 32'h22, 32'h2, 1'b0);
        send_command(oaht_pkg::CMD_ADD, 32'h33, 32'h3, 1'b0);
        send_command(oaht_pkg::CMD_GET, 32'h22, 32'h0, 1'b0);
        send_command(oaht_pkg::CMD_REMOVE, 32'h11, 32'h0, 1'b0);
        send_command(oaht_pkg::CMD_REMOVE, 32'h22, 32'h0, 1'b0);
        wait_drained();

        // small table with heavy load and a long receiver hold-off
        write_reg(REG_SIZE, 32'd3);
        write_reg(REG_SEED, $urandom());
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
            random_phase(120, 12);
        join
        wait_drained();

        // out-of-range sizes clamp; size zero then fifteen
        write_reg(REG_SIZE, 32'd0);
        random_phase(40, 4);
        wait_drained();
        write_reg(REG_SIZE, 32'd15);
        write_reg(REG_SEED, 32'h0);
        no_idle = 1'b1;
        random_phase(100, 60);
        no_idle = 1'b0;
        wait_drained();

        write_reg(REG_SIZE, 32'd6);
        write_reg(REG_SEED, $urandom());
        random_phase(150, 50);
        wait_drained();
        write_reg(REG_SIZE, 32'd10);
        random_phase(140, 200);
        wait_drained();

        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/oaht_pkg.sv
rtl/core/open_addressing_hash_table_core.sv
rtl/core/oaht_checker.sv
tb/open_addressing_hash_table_core_test.sv
